FILE: sv/impact_pulse_detector_defines.svh
// assertion macros for the impact pulse detector
`ifndef IMPACT_PULSE_DETECTOR_DEFINES_SVH
`define IMPACT_PULSE_DETECTOR_DEFINES_SVH

`ifndef NO_ASSERTIONS
// property that must hold on every clock edge outside reset
`define IPD_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("impact_pulse_detector: check failed");
// condition in one cycle that requires another in the next cycle
`define IPD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("impact_pulse_detector: check failed");
`else
`define IPD_ASSERT(label, prop)
`define IPD_ASSERT_NEXT(label, ante, cons)
`endif

`endif

FILE: sv/ipd_pkg.sv
// types and constants of the impact pulse detector
`timescale 1ns / 1ps

package ipd_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int INDEX_W   = 32;
    localparam int MAG_W     = 15;
    localparam int COUNT_W   = 7;
    localparam int CFG_IDX_W = 1;
    localparam int S_DATA_W  = 48;
    localparam int S_USER_W  = 2;
    localparam int M_DATA_W  = 96;
    localparam int M_USER_W  = 1;

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_START  = 2'd1,
        OP_STOP   = 2'd2
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET_IMPACTS = 1'b0,
        REG_MIN_IMPACTS    = 1'b1
    } cfg_reg_t;

    localparam logic [COUNT_W-1:0]  TARGET_RESET = 7'd100;
    localparam logic [COUNT_W-1:0]  MIN_RESET    = 7'd10;
    localparam logic [COUNT_W-1:0]  COUNT_MAX    = '1;
    localparam logic [MAG_W-1:0]    MAG_MAX      = '1;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MIN   = 16'h8000;

endpackage

FILE: sv/impact_pulse_detector.sv
// impact pulse detector: zero-crossing pulse capture with peak tracking
`timescale 1ns / 1ps

// Takes one request per cycle: a sample with its index, or a start or stop
// command, and returns exactly one result per request. A request is captured in
// an input register and is evaluated by a single compare-and-update stage into
// the result register, so the throughput is one request per clock while
// m_tready stays high; a stalled result stops the flow only once the input
// register is also full.
// target_impacts and min_impacts are written through cfg_we/cfg_index/cfg_wdata
// and must only change while no request is in flight.

`include "impact_pulse_detector_defines.svh"

module impact_pulse_detector (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration
    input  logic                              cfg_we,
    input  logic [ipd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ipd_pkg::COUNT_W-1:0]       cfg_wdata,
    // requests
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [ipd_pkg::S_DATA_W-1:0]      s_tdata,  // sample[15:0], sample_pos[47:16]
    input  logic [ipd_pkg::S_USER_W-1:0]      s_tuser,  // operation[1:0]
    // results
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // edge_index[31:0], peak_ofs[63:32], peak_magnitude[78:64],
    // impact_number[85:79], measurement_done[86], stop_accepted[87],
    // measuring[88], zero fill [95:89]
    output logic [ipd_pkg::M_DATA_W-1:0]      m_tdata,
    output logic [ipd_pkg::M_USER_W-1:0]      m_tuser   // impact_valid[0]
);
    import ipd_pkg::*;

    // configuration registers
    logic [COUNT_W-1:0]  target_reg;
    logic [COUNT_W-1:0]  min_reg;

    // input stage
    logic                in_valid_reg;
    logic [1:0]          in_op_reg;
    logic [SAMPLE_W-1:0] in_sample_reg;
    logic [INDEX_W-1:0]  in_index_reg;

    // detector state
    logic                active_reg,   active_next;
    logic                armed_reg,    armed_next;
    logic [SAMPLE_W-1:0] prev_reg,     prev_next;
    logic [INDEX_W-1:0]  edge_reg,     edge_next;
    logic [INDEX_W-1:0]  peak_pos_reg, peak_pos_next;
    logic [MAG_W-1:0]    peak_lvl_reg, peak_lvl_next;
    logic [COUNT_W-1:0]  total_reg,    total_next;

    // result stage
    logic                m_valid_reg;
    logic                valid_reg,    valid_next;
    logic [INDEX_W-1:0]  edge_out_reg, edge_out_next;
    logic [INDEX_W-1:0]  off_out_reg,  off_out_next;
    logic [MAG_W-1:0]    mag_out_reg,  mag_out_next;
    logic                done_reg,     done_next;
    logic                acc_reg,      acc_next;

    logic                advance;
    logic                s_accept;
    logic                rising;
    logic                falling;
    logic                prev_neg;
    logic                prev_pos;
    logic                cur_nonpos;
    logic [MAG_W-1:0]    mag;
    logic [COUNT_W-1:0]  total_inc;

    assign advance  = !m_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    assign prev_neg   = prev_reg[SAMPLE_W-1];
    assign prev_pos   = !prev_reg[SAMPLE_W-1] && (prev_reg != '0);
    assign cur_nonpos = in_sample_reg[SAMPLE_W-1] || (in_sample_reg == '0);

    // magnitude with the most negative sample clipped to full scale
    always_comb begin
        if (!in_sample_reg[SAMPLE_W-1]) begin
            mag = in_sample_reg[MAG_W-1:0];
        end else if (in_sample_reg == SAMPLE_MIN) begin
            mag = MAG_MAX;
        end else begin
            mag = MAG_W'(SAMPLE_W'(-in_sample_reg));
        end
    end

    assign total_inc = (total_reg == COUNT_MAX) ? total_reg : total_reg + COUNT_W'(1);

    always_comb begin
        active_next   = active_reg;
        armed_next    = armed_reg;
        prev_next     = prev_reg;
        edge_next     = edge_reg;
        peak_pos_next = peak_pos_reg;
        peak_lvl_next = peak_lvl_reg;
        total_next    = total_reg;
        valid_next    = 1'b0;
        edge_out_next = '0;
        off_out_next  = '0;
        mag_out_next  = '0;
        done_next     = 1'b0;
        acc_next      = 1'b0;
        rising        = 1'b0;
        falling       = 1'b0;

        case (op_t'(in_op_reg))
            OP_START: begin
                active_next = 1'b1;
                total_next  = '0;
            end
            OP_STOP: begin
                if (active_reg && total_reg >= min_reg) begin
                    active_next = 1'b0;
                    done_next   = 1'b1;
                    acc_next    = 1'b1;
                end
            end
            OP_SAMPLE: begin
                if (active_reg) begin
                    rising = !armed_reg && prev_neg && !in_sample_reg[SAMPLE_W-1];
                    if (rising) begin
                        armed_next    = 1'b1;
                        edge_next     = in_index_reg;
                        peak_lvl_next = '0;
                        peak_pos_next = in_index_reg;
                    end
                    if (armed_next) begin
                        if (mag > peak_lvl_next) begin
                            peak_lvl_next = mag;
                            peak_pos_next = in_index_reg;
                        end
                        falling = (in_index_reg > peak_pos_next) && prev_pos && cur_nonpos;
                        if (falling) begin
                            total_next    = total_inc;
                            valid_next    = 1'b1;
                            edge_out_next = edge_next;
                            off_out_next  = peak_pos_next - edge_next;
                            mag_out_next  = peak_lvl_next;
                            armed_next    = 1'b0;
                            // automatic stop still honours the minimum count
                            if (total_inc >= target_reg && total_inc >= min_reg) begin
                                active_next = 1'b0;
                                done_next   = 1'b1;
                            end
                        end
                    end
                    prev_next = in_sample_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg <= TARGET_RESET;
            min_reg    <= MIN_RESET;
        end else if (cfg_we) begin
            case (cfg_reg_t'(cfg_index))
                REG_TARGET_IMPACTS: target_reg <= cfg_wdata;
                REG_MIN_IMPACTS:    min_reg    <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_accept) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_op_reg     <= s_tuser[1:0];
            in_sample_reg <= s_tdata[15:0];
            in_index_reg  <= s_tdata[47:16];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg   <= 1'b0;
            armed_reg    <= 1'b0;
            prev_reg     <= '0;
            edge_reg     <= '0;
            peak_pos_reg <= '0;
            peak_lvl_reg <= '0;
            total_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= in_valid_reg;
            if (in_valid_reg) begin
                active_reg   <= active_next;
                armed_reg    <= armed_next;
                prev_reg     <= prev_next;
                edge_reg     <= edge_next;
                peak_pos_reg <= peak_pos_next;
                peak_lvl_reg <= peak_lvl_next;
                total_reg    <= total_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid_reg) begin
            valid_reg    <= valid_next;
            edge_out_reg <= edge_out_next;
            off_out_reg  <= off_out_next;
            mag_out_reg  <= mag_out_next;
            done_reg     <= done_next;
            acc_reg      <= acc_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = valid_reg;
    // count and measuring follow the state left by the request just delivered
    assign m_tdata  = {7'd0, active_reg, acc_reg, done_reg, total_reg,
                       mag_out_reg, off_out_reg, edge_out_reg};

    `IPD_ASSERT(a_stop_flags, (m_valid_reg && acc_reg) |-> (done_reg && !active_reg))
    `IPD_ASSERT(a_idle_result_zero, (m_valid_reg && !valid_reg) |->
        (edge_out_reg == '0 && off_out_reg == '0 && mag_out_reg == '0))
    `IPD_ASSERT_NEXT(a_start_clears, (advance && in_valid_reg && in_op_reg == OP_START),
        (active_reg && total_reg == '0))
    `IPD_ASSERT_NEXT(a_count_monotonic, (advance && in_valid_reg && in_op_reg != OP_START),
        (total_reg >= $past(total_reg)))
    `IPD_ASSERT(a_impact_disarms, (m_valid_reg && valid_reg) |-> !armed_reg)

endmodule
